[rtl/bounded_vector_insert_erase_top_macros.svh]
// Assertion macros shared by the checker of the bounded vector block.
`ifndef BOUNDED_VECTOR_INSERT_ERASE_TOP_MACROS_SVH
`define BOUNDED_VECTOR_INSERT_ERASE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVIE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bvie assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BVIE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bvie assertion failed");

`endif

[rtl/bvie_pkg.sv]
`default_nettype none

package bvie_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_FILL   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOROOM = 2'd3
  } status_e;

  function automatic logic [ELEM_W-1:0] to_elem(logic [31:0] v);
    logic signed [31:0] s;
    logic signed [63:0] t;
    s = signed'(v);
    t = 64'(s);
    return t[ELEM_W-1:0];
  endfunction

  function automatic logic [31:0] from_elem(logic [ELEM_W-1:0] e);
    logic signed [ELEM_W-1:0] s;
    logic signed [63:0] t;
    s = signed'(e);
    t = 64'(s);
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/bvie_intf.sv]
`default_nettype none

interface bvie_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [5:0]         position;
  logic signed [31:0] element_value;
  logic [6:0]         fill_count;

  modport source (output valid, operation, position, element_value, fill_count,
                  input ready);
  modport sink (input valid, operation, position, element_value, fill_count,
                output ready);
endinterface

interface bvie_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [6:0]         count_now;
  logic               is_empty;
  logic signed [31:0] first_value;
  logic signed [31:0] last_value;

  modport source (output valid, status, read_value, count_now, is_empty,
                  first_value, last_value, input ready);
  modport sink (input valid, status, read_value, count_now, is_empty,
                first_value, last_value, output ready);
endinterface

`default_nettype wire

[rtl/bounded_vector_insert_erase_top.sv]
`default_nettype none
// Bounded ordered list of signed elements with a fixed store and a count.
// The input channel in_i takes one operation per beat: append, remove last,
// insert, erase, read, clear or fill. The output channel out_o returns one
// result beat per operation with status, read data, count, empty flag and
// the first and last elements.
// The input is ready only while the sequencer is idle. Insert and erase shift
// the elements behind the position one place up or down, and fill writes the
// fill value into each entry up to the fill count; the single write port of
// the element memory moves one element per cycle.
// A finished result sits in the output register while the next operation is
// accepted; if the receiver stalls, the sequencer waits before its final
// step until that register is free.
// Reset empties the list at once; store entries keep no reset value.

module bounded_vector_insert_erase_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  bvie_in_if.sink      in_i,
  bvie_out_if.source   out_o
);

  localparam int AW = bvie_pkg::ADDR_W;
  localparam int CW = bvie_pkg::CNT_W;
  localparam int EW = bvie_pkg::ELEM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_FILL, S_SHUP, S_SHUPL, S_INSWR, S_SHDN, S_SHDNL,
    S_READFL, S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [EW-1:0]     val_q, val_d;
  logic [CW-1:0]     fcnt_q, fcnt_d;
  bvie_pkg::status_e status_q, status_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              pend_q, pend_d;
  logic [31:0]       rv_q, rv_d;

  logic              ov_q, ov_d;
  bvie_pkg::status_e o_status_q, o_status_d;
  logic [31:0]       o_rv_q, o_rv_d;
  logic [CW-1:0]     o_cnt_q, o_cnt_d;
  logic              o_empty_q, o_empty_d;
  logic [31:0]       o_first_q, o_first_d;
  logic [31:0]       o_last_q, o_last_d;

  logic [EW-1:0]     mem [bvie_pkg::CAPACITY];
  logic [EW-1:0]     rd_a_q, rd_b_q;
  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [EW-1:0]     wdata;

  logic [CW-1:0]     in_pos;
  bvie_pkg::status_e in_status;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  always_comb begin
    in_pos = CW'(in_i.position);
    in_status = bvie_pkg::ST_OK;
    case (bvie_pkg::op_e'(in_i.operation))
      bvie_pkg::OP_APPEND: begin
        if (count_q >= CW'(bvie_pkg::CAPACITY)) in_status = bvie_pkg::ST_NOROOM;
      end
      bvie_pkg::OP_POP: begin
        if (count_q == '0) in_status = bvie_pkg::ST_EMPTY;
      end
      bvie_pkg::OP_INSERT: begin
        if (in_pos >= count_q) in_status = bvie_pkg::ST_RANGE;
        else if (count_q >= CW'(bvie_pkg::CAPACITY)) in_status = bvie_pkg::ST_NOROOM;
      end
      bvie_pkg::OP_ERASE, bvie_pkg::OP_READ: begin
        if (in_pos >= count_q) in_status = bvie_pkg::ST_RANGE;
      end
      bvie_pkg::OP_FILL: begin
        if (in_i.fill_count > CW'(bvie_pkg::CAPACITY)) in_status = bvie_pkg::ST_NOROOM;
      end
      default: in_status = bvie_pkg::ST_OK;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pos_d      = pos_q;
    val_d      = val_q;
    fcnt_d     = fcnt_q;
    status_d   = status_q;
    count_d    = count_q;
    idx_d      = idx_q;
    wr_addr_d  = wr_addr_q;
    pend_d     = pend_q;
    rv_d       = rv_q;
    ov_d       = ov_q;
    o_status_d = o_status_q;
    o_rv_d     = o_rv_q;
    o_cnt_d    = o_cnt_q;
    o_empty_d  = o_empty_q;
    o_first_d  = o_first_q;
    o_last_d   = o_last_q;
    we         = 1'b0;
    waddr      = wr_addr_q;
    wdata      = rd_a_q;
    raddr_a    = idx_q;
    raddr_b    = AW'(count_q - 1'b1);

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = in_i.operation;
          pos_d    = AW'(in_i.position);
          val_d    = bvie_pkg::to_elem(in_i.element_value);
          fcnt_d   = in_i.fill_count;
          status_d = in_status;
          rv_d     = '0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_d  = 1'b0;
        state_d = S_READFL;
        if (status_q == bvie_pkg::ST_OK) begin
          case (bvie_pkg::op_e'(op_q))
            bvie_pkg::OP_APPEND: begin
              we      = 1'b1;
              waddr   = AW'(count_q);
              wdata   = val_q;
              count_d = count_q + 1'b1;
            end
            bvie_pkg::OP_POP:   count_d = count_q - 1'b1;
            bvie_pkg::OP_CLEAR: count_d = '0;
            bvie_pkg::OP_READ:  raddr_a = pos_q;
            bvie_pkg::OP_FILL: begin
              if (fcnt_q == '0) begin
                count_d = '0;
              end else begin
                idx_d   = '0;
                state_d = S_FILL;
              end
            end
            bvie_pkg::OP_INSERT: begin
              idx_d   = AW'(count_q - 1'b1);
              state_d = S_SHUP;
            end
            bvie_pkg::OP_ERASE: begin
              if (CW'(pos_q) == count_q - 1'b1) begin
                count_d = count_q - 1'b1;
              end else begin
                idx_d   = pos_q + 1'b1;
                state_d = S_SHDN;
              end
            end
            default: state_d = S_READFL;
          endcase
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = val_q;
        if (CW'(idx_q) == fcnt_q - 1'b1) begin
          count_d = fcnt_q;
          state_d = S_READFL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SHUP: begin
        raddr_a   = idx_q;
        wr_addr_d = idx_q + 1'b1;
        pend_d    = 1'b1;
        we        = pend_q;
        if (idx_q == pos_q) state_d = S_SHUPL;
        else idx_d = idx_q - 1'b1;
      end
      S_SHUPL: begin
        we      = 1'b1;
        state_d = S_INSWR;
      end
      S_INSWR: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        count_d = count_q + 1'b1;
        state_d = S_READFL;
      end
      S_SHDN: begin
        raddr_a   = idx_q;
        wr_addr_d = idx_q - 1'b1;
        pend_d    = 1'b1;
        we        = pend_q;
        if (CW'(idx_q) == count_q - 1'b1) state_d = S_SHDNL;
        else idx_d = idx_q + 1'b1;
      end
      S_SHDNL: begin
        we      = 1'b1;
        count_d = count_q - 1'b1;
        state_d = S_READFL;
      end
      S_READFL: begin
        raddr_a = '0;
        if (bvie_pkg::op_e'(op_q) == bvie_pkg::OP_READ && status_q == bvie_pkg::ST_OK) begin
          rv_d = bvie_pkg::from_elem(rd_a_q);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        raddr_a = '0;
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_rv_d     = rv_q;
          o_cnt_d    = count_q;
          o_empty_d  = (count_q == '0);
          o_first_d  = (count_q == '0) ? '0 : bvie_pkg::from_elem(rd_a_q);
          o_last_d   = (count_q == '0) ? '0 : bvie_pkg::from_elem(rd_b_q);
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= '0;
      pos_q      <= '0;
      val_q      <= '0;
      fcnt_q     <= '0;
      status_q   <= bvie_pkg::ST_OK;
      count_q    <= '0;
      idx_q      <= '0;
      wr_addr_q  <= '0;
      pend_q     <= 1'b0;
      rv_q       <= '0;
      ov_q       <= 1'b0;
      o_status_q <= bvie_pkg::ST_OK;
      o_rv_q     <= '0;
      o_cnt_q    <= '0;
      o_empty_q  <= 1'b1;
      o_first_q  <= '0;
      o_last_q   <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      pos_q      <= pos_d;
      val_q      <= val_d;
      fcnt_q     <= fcnt_d;
      status_q   <= status_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      wr_addr_q  <= wr_addr_d;
      pend_q     <= pend_d;
      rv_q       <= rv_d;
      ov_q       <= ov_d;
      o_status_q <= o_status_d;
      o_rv_q     <= o_rv_d;
      o_cnt_q    <= o_cnt_d;
      o_empty_q  <= o_empty_d;
      o_first_q  <= o_first_d;
      o_last_q   <= o_last_d;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.status      = o_status_q;
  assign out_o.read_value  = signed'(o_rv_q);
  assign out_o.count_now   = o_cnt_q;
  assign out_o.is_empty    = o_empty_q;
  assign out_o.first_value = signed'(o_first_q);
  assign out_o.last_value  = signed'(o_last_q);

endmodule

`default_nettype wire

[rtl/bvie_checker.sv]
`default_nettype none
`include "bounded_vector_insert_erase_top_macros.svh"

module bvie_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_i,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire [1:0]         status_i,
  input wire signed [31:0] read_value_i,
  input wire [6:0]         count_now_i,
  input wire               is_empty_i,
  input wire signed [31:0] first_value_i,
  input wire signed [31:0] last_value_i
);

  `BVIE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `BVIE_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(status_i) && $stable(read_value_i) && $stable(count_now_i) && $stable(is_empty_i) && $stable(first_value_i) && $stable(last_value_i))
  `BVIE_ASSERT_NOW(a_count_flag, out_valid_i, (is_empty_i == (count_now_i == 7'd0)) && (count_now_i <= 7'(bvie_pkg::CAPACITY)))
  `BVIE_ASSERT_NOW(a_empty_ends, out_valid_i && is_empty_i, (first_value_i == 32'sd0) && (last_value_i == 32'sd0))
  `BVIE_ASSERT_NEXT(a_busy_after_beat, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind bounded_vector_insert_erase_top bvie_checker u_bvie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .read_value_i  (out_o.read_value),
  .count_now_i   (out_o.count_now),
  .is_empty_i    (out_o.is_empty),
  .first_value_i (out_o.first_value),
  .last_value_i  (out_o.last_value)
);

`default_nettype wire
